// ----- rtl/closest_pair_min_distance_unit_assert.svh -----
// Assertion macros for the closest pair unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CLOSEST_PAIR_MIN_DISTANCE_UNIT_ASSERT_SVH
`define CLOSEST_PAIR_MIN_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CPMD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CPMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cpmd_pkg.sv -----
`default_nettype none

package cpmd_pkg;

    localparam int COORD_W         = 16;
    localparam int DIST_W          = 36;
    localparam int ROOT_W          = 18;
    localparam int ROOT_STEPS      = DIST_W / 2;
    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_BITS_DEF  = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_ROOT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } cpmd_state_t;

endpackage

`default_nettype wire

// ----- rtl/closest_pair_min_distance_unit.sv -----
// Channel  Handshake                  Payload
// point    point_valid / point_stall  coord_x, coord_y, last_point
// result   result_valid / result_stall min_dist_sq, min_dist_root, pair_found,
//                                      capacity_exceeded
//
// A point that finds N >= 1 points already stored is scanned against them: one
// read of the point store per cycle feeds a single subtract, square and compare
// pipeline three stages deep. A point with the last mark then passes through the
// bit-serial square root, after which the result register is loaded. A point
// that finds the store empty or full skips the scan.
// rst_n clears control state at once; the point store holds no reset value.
// result_stall holds back the next result load, and no point is taken meanwhile.
`default_nettype none
`include "closest_pair_min_distance_unit_assert.svh"

module closest_pair_min_distance_unit #(
    parameter int MAX_POINTS = cpmd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cpmd_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 point_valid,
    output logic                                      point_stall,
    input  wire logic signed [cpmd_pkg::COORD_W-1:0]  coord_x,
    input  wire logic signed [cpmd_pkg::COORD_W-1:0]  coord_y,
    input  wire logic                                 last_point,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic [cpmd_pkg::DIST_W-1:0]               min_dist_sq,
    output logic [cpmd_pkg::ROOT_W-1:0]               min_dist_root,
    output logic                                      pair_found,
    output logic                                      capacity_exceeded
);
    import cpmd_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 2 * COORD_BITS;
    localparam int RAW_W  = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int EXT_W  = (SQ_W + 1 > DIST_W) ? SQ_W + 1 : DIST_W + 1;
    localparam int REM_W  = ROOT_W + 3;
    localparam int RCNT_W = $clog2(ROOT_STEPS);

    cpmd_state_t state_reg, state_next;

    logic [CNT_W-1:0]  point_count_reg;
    logic [CNT_W-1:0]  scan_last_reg;
    logic [ADDR_W-1:0] scan_idx_reg;
    logic              last_reg;
    logic [DIST_W-1:0] running_min_reg;
    logic              min_valid_reg;
    logic              overflow_seen_reg;

    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg;

    logic [PT_W-1:0]       store_mem [MAX_POINTS];
    logic [PT_W-1:0]       rd_data_reg;
    logic                  v1_reg, v2_reg, v3_reg;
    logic [COORD_BITS-1:0] adx_reg, ady_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;

    logic [DIST_W-1:0] sqrt_v_reg;
    logic [REM_W-1:0]  sqrt_rem_reg;
    logic [ROOT_W-1:0] sqrt_root_reg;
    logic [RCNT_W-1:0] sqrt_cnt_reg;
    logic [DIST_W-1:0] dist_hold_reg;
    logic              pair_hold_reg;
    logic              ovf_hold_reg;

    logic              result_valid_reg;
    logic [DIST_W-1:0] min_dist_sq_reg;
    logic [ROOT_W-1:0] min_dist_root_reg;
    logic              pair_found_reg;
    logic              capacity_exceeded_reg;

    logic [RAW_W-1:0]             raw_x, raw_y;
    logic signed [COORD_BITS-1:0] x_in, y_in;
    logic                         accept;
    logic                         store_ok;
    logic                         mem_re;
    logic                         scan_done;
    logic                         pipe_empty;
    logic                         root_start;
    logic                         emit_fire;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [COORD_BITS:0]          dx, dy;
    logic [COORD_BITS:0]          dx_abs, dy_abs;
    logic [EXT_W-1:0]             sum_ext;
    logic [DIST_W-1:0]            dist_sat;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              trial_ge;

    // Bits above COORD_BITS are ignored; the low COORD_BITS bits form a signed coordinate.
    assign raw_x = RAW_W'($unsigned(coord_x));
    assign raw_y = RAW_W'($unsigned(coord_y));
    assign x_in  = raw_x[COORD_BITS-1:0];
    assign y_in  = raw_y[COORD_BITS-1:0];

    assign point_stall = (state_reg != ST_IDLE);
    assign accept      = point_valid && !point_stall;
    assign store_ok    = (point_count_reg < CNT_W'(MAX_POINTS));
    assign mem_re      = (state_reg == ST_SCAN);
    assign scan_done   = (CNT_W'(scan_idx_reg) == scan_last_reg);
    assign pipe_empty  = !(v1_reg || v2_reg || v3_reg);
    assign root_start  = (state_reg == ST_DRAIN) && pipe_empty && last_reg;
    assign emit_fire   = (state_reg == ST_EMIT) && !(result_valid_reg && result_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (store_ok && (point_count_reg != '0))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_DRAIN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                    state_next = last_reg ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                if (sqrt_cnt_reg == RCNT_W'(ROOT_STEPS - 1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Point store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
            store_mem[point_count_reg[ADDR_W-1:0]] <= {x_in, y_in};
        if (mem_re)
            rd_data_reg <= store_mem[scan_idx_reg];
    end

    // Distance pipeline: absolute differences, squares, then sum and compare.
    assign rd_x = rd_data_reg[PT_W-1:COORD_BITS];
    assign rd_y = rd_data_reg[COORD_BITS-1:0];
    assign dx   = {rd_x[COORD_BITS-1], rd_x} - {pt_x_reg[COORD_BITS-1], pt_x_reg};
    assign dy   = {rd_y[COORD_BITS-1], rd_y} - {pt_y_reg[COORD_BITS-1], pt_y_reg};
    assign dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

    assign sum_ext  = EXT_W'(sqx_reg) + EXT_W'(sqy_reg);
    assign dist_sat = (sum_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : sum_ext[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_x_reg <= x_in;
            pt_y_reg <= y_in;
        end
        if (v1_reg)
        begin
            adx_reg <= dx_abs[COORD_BITS-1:0];
            ady_reg <= dy_abs[COORD_BITS-1:0];
        end
        if (v2_reg)
        begin
            sqx_reg <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            sqy_reg <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        end
    end

    // Square root, one result bit per cycle.
    assign rem_sh   = {sqrt_rem_reg[REM_W-3:0], sqrt_v_reg[DIST_W-1 -: 2]};
    assign trial    = REM_W'({sqrt_root_reg, 2'b01});
    assign trial_ge = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            point_count_reg   <= '0;
            scan_last_reg     <= '0;
            scan_idx_reg      <= '0;
            last_reg          <= 1'b0;
            running_min_reg   <= '0;
            min_valid_reg     <= 1'b0;
            overflow_seen_reg <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            sqrt_cnt_reg      <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= mem_re;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;

            if (accept)
            begin
                last_reg     <= last_point;
                scan_idx_reg <= '0;
                if (store_ok)
                begin
                    point_count_reg <= point_count_reg + 1'b1;
                    scan_last_reg   <= point_count_reg - 1'b1;
                end
                else
                begin
                    overflow_seen_reg <= 1'b1;
                end
            end

            if (mem_re)
                scan_idx_reg <= scan_idx_reg + 1'b1;

            if (v3_reg && (!min_valid_reg || (dist_sat < running_min_reg)))
            begin
                running_min_reg <= dist_sat;
                min_valid_reg   <= 1'b1;
            end

            // Hand the set to the root stage and clear it for the next set.
            if (root_start)
            begin
                point_count_reg   <= '0;
                running_min_reg   <= '0;
                min_valid_reg     <= 1'b0;
                overflow_seen_reg <= 1'b0;
                sqrt_cnt_reg      <= '0;
            end
            else if (state_reg == ST_ROOT)
            begin
                sqrt_cnt_reg <= sqrt_cnt_reg + 1'b1;
            end

            if (emit_fire)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_start)
        begin
            sqrt_v_reg    <= min_valid_reg ? running_min_reg : '0;
            dist_hold_reg <= min_valid_reg ? running_min_reg : '0;
            pair_hold_reg <= min_valid_reg;
            ovf_hold_reg  <= overflow_seen_reg;
            sqrt_rem_reg  <= '0;
            sqrt_root_reg <= '0;
        end
        else if (state_reg == ST_ROOT)
        begin
            sqrt_v_reg    <= {sqrt_v_reg[DIST_W-3:0], 2'b00};
            sqrt_rem_reg  <= trial_ge ? (rem_sh - trial) : rem_sh;
            sqrt_root_reg <= {sqrt_root_reg[ROOT_W-2:0], trial_ge};
        end

        if (emit_fire)
        begin
            min_dist_sq_reg       <= dist_hold_reg;
            min_dist_root_reg     <= sqrt_root_reg;
            pair_found_reg        <= pair_hold_reg;
            capacity_exceeded_reg <= ovf_hold_reg;
        end
    end

    assign result_valid      = result_valid_reg;
    assign min_dist_sq       = min_dist_sq_reg;
    assign min_dist_root     = min_dist_root_reg;
    assign pair_found        = pair_found_reg;
    assign capacity_exceeded = capacity_exceeded_reg;

    `CPMD_ASSERT_IMPLY(a_pipe_in_scan, !pipe_empty,
        (state_reg == ST_SCAN) || (state_reg == ST_DRAIN), "distance pipeline busy outside scan")
    `CPMD_ASSERT_IMPLY(a_count_bound, 1'b1,
        point_count_reg <= CNT_W'(MAX_POINTS), "point count beyond store depth")
    `CPMD_ASSERT_NEXT(a_count_step, accept && store_ok,
        point_count_reg == $past(point_count_reg) + 1'b1, "stored point not counted")
    `CPMD_ASSERT_NEXT(a_emit_loads, emit_fire,
        result_valid_reg, "result load lost")

endmodule

`default_nettype wire
